@@ rtl/ids_pkg.sv @@
// Shared types and constants for the image difference statistics block.
package ids_pkg;

  localparam int unsigned NumCh    = 4;
  localparam int unsigned CntW     = 25;
  localparam int unsigned SumW     = 32;
  localparam int unsigned SqW      = 40;
  localparam int unsigned StepW    = 6;

  // channel count ceiling and pixel count ceiling of the statistics
  localparam logic [2:0]      MaxChannels = 3'd4;
  localparam logic [CntW-1:0] MaxPixels   = 25'd16777216;

  // iteration counts of the shared divider and the square root unit
  localparam logic [StepW-1:0] DivSteps  = 6'd32;
  localparam logic [StepW-1:0] RootSteps = 6'd16;

  typedef enum logic [2:0] {
    CFG_FIRST_COUNT  = 3'd0,
    CFG_SECOND_COUNT = 3'd1,
    CFG_OUT_COUNT    = 3'd2,
    CFG_THRESHOLD    = 3'd3,
    CFG_SCALE        = 3'd4
  } ids_cfg_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_MEAN = 2'd1,
    ST_RMS  = 2'd2,
    ST_ROOT = 2'd3
  } ids_state_e;

  typedef struct packed {
    logic accept;       // item taken this cycle
    logic accept_last;  // item taken is the last pixel of the frame
    logic div_step;     // one divider iteration
    logic mean_done;    // capture mean, load RMS division
    logic rms_done;     // load square root from quotient
    logic root_step;    // one square root iteration
    logic finish;       // capture RMS
  } ids_cmd_t;

endpackage

@@ rtl/ids_ctrl.sv @@
// Sequencer: handshakes, frame-end divide and square root sequencing.
module ids_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            last_pixel_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output ids_pkg::ids_cmd_t cmd_o
);
  import ids_pkg::*;

  ids_state_e       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_ready;
  ids_cmd_t         cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    in_ready    = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
    case (state_q)
      ST_RUN: begin
        if (in_valid_i && in_ready) begin
          cmd.accept = 1'b1;
          if (last_pixel_i) begin
            cmd.accept_last = 1'b1;
            cnt_d           = '0;
            state_d         = ST_MEAN;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_MEAN: begin
        if (cnt_q == DivSteps) begin
          cmd.mean_done = 1'b1;
          cnt_d         = '0;
          state_d       = ST_RMS;
        end else begin
          cmd.div_step = 1'b1;
          cnt_d        = StepW'(cnt_q + 1'b1);
        end
      end
      ST_RMS: begin
        if (cnt_q == DivSteps) begin
          cmd.rms_done = 1'b1;
          cnt_d        = '0;
          state_d      = ST_ROOT;
        end else begin
          cmd.div_step = 1'b1;
          cnt_d        = StepW'(cnt_q + 1'b1);
        end
      end
      ST_ROOT: begin
        if (cnt_q == RootSteps) begin
          cmd.finish  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_RUN;
        end else begin
          cmd.root_step = 1'b1;
          cnt_d         = StepW'(cnt_q + 1'b1);
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

@@ rtl/ids_datapath.sv @@
// Datapath: config registers, pixel diff, frame statistics, divider, square root.
module ids_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ids_pkg::ids_cmd_t           cmd_i,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic [ids_pkg::NumCh-1:0][7:0] a_i,
  input  logic [ids_pkg::NumCh-1:0][7:0] b_i,
  output logic [ids_pkg::NumCh-1:0][7:0] out_ch_o,
  output logic [7:0]                  pixel_max_diff_o,
  output logic                        frame_done_o,
  output logic [ids_pkg::CntW-1:0]    differing_pixels_o,
  output logic [ids_pkg::CntW-1:0]    above_threshold_pixels_o,
  output logic [7:0]                  frame_max_diff_o,
  output logic [15:0]                 mean_diff_o,
  output logic [15:0]                 rms_diff_o
);
  import ids_pkg::*;

  function automatic logic [2:0] clamp_cnt(input logic [2:0] c, input logic lo_one);
    logic [2:0] r;
    r = c;
    if (lo_one && (c == 3'd0)) r = 3'd1;
    if (r > MaxChannels) r = MaxChannels;
    return r;
  endfunction

  // configuration registers
  logic [2:0]  first_cnt_q, second_cnt_q, out_cnt_q;
  logic [7:0]  thr_q;
  logic [15:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= 3'd4;
      second_cnt_q <= 3'd4;
      out_cnt_q    <= 3'd0;
      thr_q        <= 8'd0;
      scale_q      <= 16'd256;
    end else if (cfg_we_i) begin
      case (ids_cfg_e'(cfg_index_i))
        CFG_FIRST_COUNT:  first_cnt_q  <= cfg_data_i[2:0];
        CFG_SECOND_COUNT: second_cnt_q <= cfg_data_i[2:0];
        CFG_OUT_COUNT:    out_cnt_q    <= cfg_data_i[2:0];
        CFG_THRESHOLD:    thr_q        <= cfg_data_i[7:0];
        CFG_SCALE:        scale_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-pixel difference
  logic [2:0]            n1, n2, nsrc, ndiff;
  logic [NumCh-1:0][7:0] dch;
  logic [NumCh-1:0][7:0] vch;
  logic [7:0]            pix;
  logic [23:0]           prod [NumCh];

  always_comb begin
    n1    = clamp_cnt(first_cnt_q, 1'b1);
    n2    = clamp_cnt(second_cnt_q, 1'b1);
    nsrc  = (n1 < n2) ? n1 : n2;
    ndiff = (out_cnt_q != 3'd0) ? clamp_cnt(out_cnt_q, 1'b0) : nsrc;
    pix   = 8'd0;
    for (int ch = 0; ch < NumCh; ch++) begin
      dch[ch]  = (a_i[ch] > b_i[ch]) ? 8'(a_i[ch] - b_i[ch]) : 8'(b_i[ch] - a_i[ch]);
      prod[ch] = {16'd0, dch[ch]} * {8'd0, scale_q};
      vch[ch]  = 8'd0;
      if (3'(ch) < nsrc) begin
        if (dch[ch] > pix) pix = dch[ch];
        if (3'(ch) < ndiff) begin
          vch[ch] = (prod[ch][23:16] != 8'd0) ? 8'hFF : prod[ch][15:8];
        end
      end else if (3'(ch) < ndiff) begin
        vch[ch] = (ch == NumCh - 1) ? 8'hFF : 8'd0;
      end
    end
  end

  // running statistics
  logic [CntW-1:0] nz_q, nz_d, over_q, over_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0]  sq_q, sq_d;
  logic [7:0]      max_q, max_d;
  logic [15:0]     pix_sq;

  always_comb begin
    pix_sq = {8'd0, pix} * {8'd0, pix};
    nz_d   = nz_q;
    over_d = over_q;
    sum_d  = sum_q;
    sq_d   = sq_q;
    max_d  = max_q;
    if (pix != 8'd0) begin
      if (pix > max_q) max_d = pix;
      if (nz_q < MaxPixels) begin
        nz_d  = CntW'(nz_q + 1'b1);
        sum_d = SumW'(sum_q + {24'd0, pix});
        sq_d  = SqW'(sq_q + {24'd0, pix_sq});
        if (pix > thr_q) over_d = CntW'(over_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q   <= '0;
      over_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      max_q  <= '0;
    end else if (cmd_i.accept_last) begin
      nz_q   <= '0;
      over_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      max_q  <= '0;
    end else if (cmd_i.accept) begin
      nz_q   <= nz_d;
      over_q <= over_d;
      sum_q  <= sum_d;
      sq_q   <= sq_d;
      max_q  <= max_d;
    end
  end

  // output registers; count field doubles as the divisor
  logic [NumCh-1:0][7:0] out_ch_q;
  logic [7:0]            pix_q, fmax_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_out_q, over_out_q;
  logic [15:0]           mean_q, rms_q;
  logic [SqW-1:0]        rep_sq_q;

  // shared restoring divider: rem holds the partial remainder, quo the
  // low numerator bits that turn into the quotient as they shift out
  logic [CntW-1:0] rem_q;
  logic [31:0]     quo_q;
  logic [CntW:0]   trial;
  logic            q_bit;

  always_comb begin
    trial = {rem_q, quo_q[31]};
    q_bit = (trial >= {1'b0, cnt_out_q});
  end

  // bitwise square root
  logic [31:0] v_q, r_q, bit_q;
  logic [32:0] rb;
  logic        take;

  always_comb begin
    rb   = {1'b0, r_q} + {1'b0, bit_q};
    take = ({1'b0, v_q} >= rb);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      out_ch_q <= vch;
      pix_q    <= pix;
      done_q   <= cmd_i.accept_last;
      if (cmd_i.accept_last) begin
        cnt_out_q  <= nz_d;
        over_out_q <= over_d;
        fmax_q     <= max_d;
        rep_sq_q   <= sq_d;
        // numerator sum * 256, 40 bits wide, top 8 bits into the remainder
        rem_q      <= {9'd0, 8'd0, sum_d[31:24]};
        quo_q      <= {sum_d[23:0], 8'd0};
      end else begin
        cnt_out_q  <= '0;
        over_out_q <= '0;
        fmax_q     <= '0;
      end
      mean_q <= '0;
      rms_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? CntW'(trial - {1'b0, cnt_out_q}) : CntW'(trial);
      quo_q <= {quo_q[30:0], q_bit};
    end
    if (cmd_i.mean_done) begin
      mean_q <= (cnt_out_q == '0) ? 16'd0 : quo_q[15:0];
      // numerator square sum * 65536
      rem_q  <= {1'b0, rep_sq_q[39:16]};
      quo_q  <= {rep_sq_q[15:0], 16'd0};
    end
    if (cmd_i.rms_done) begin
      v_q   <= quo_q;
      r_q   <= '0;
      bit_q <= 32'h4000_0000;
    end
    if (cmd_i.root_step) begin
      if (take) begin
        v_q <= 32'({1'b0, v_q} - rb);
        r_q <= 32'({1'b0, r_q[31:1]} + {1'b0, bit_q});
      end else begin
        r_q <= {1'b0, r_q[31:1]};
      end
      bit_q <= {2'b00, bit_q[31:2]};
    end
    if (cmd_i.finish) begin
      rms_q <= (cnt_out_q == '0) ? 16'd0 : r_q[15:0];
    end
  end

  assign out_ch_o                 = out_ch_q;
  assign pixel_max_diff_o         = pix_q;
  assign frame_done_o             = done_q;
  assign differing_pixels_o       = cnt_out_q;
  assign above_threshold_pixels_o = over_out_q;
  assign frame_max_diff_o         = fmax_q;
  assign mean_diff_o              = mean_q;
  assign rms_diff_o               = rms_q;

endmodule

@@ rtl/image_difference_statistics.sv @@
// Top level of the image absolute difference statistics block.
//
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------------
//  cfg     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//  in      | in_valid_i / in_ready_o      | a_ch0_i..a_ch3_i, b_ch0_i..b_ch3_i,
//          |                              | last_pixel_i
//  out     | out_valid_o / out_ready_i    | out_ch0_o..out_ch3_o, pixel_max_diff_o,
//          |                              | frame_done_o, frame statistics
//
// An ordinary pixel is accepted, and its result lands in the output register at
// the same edge; the next pixel is taken while that result is being taken. The
// last pixel of a frame starts a sequence through the shared restoring divider
// (mean, then mean square) and the 16-iteration square root. in_ready_o is low
// during that sequence and whenever the output register holds a result the
// consumer has not yet taken. Reset returns the configuration to its defaults and
// clears the statistics; cfg_ready_o is always high.
module image_difference_statistics (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  a_ch0_i,
  input  logic [7:0]  a_ch1_i,
  input  logic [7:0]  a_ch2_i,
  input  logic [7:0]  a_ch3_i,
  input  logic [7:0]  b_ch0_i,
  input  logic [7:0]  b_ch1_i,
  input  logic [7:0]  b_ch2_i,
  input  logic [7:0]  b_ch3_i,
  input  logic        last_pixel_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_ch0_o,
  output logic [7:0]  out_ch1_o,
  output logic [7:0]  out_ch2_o,
  output logic [7:0]  out_ch3_o,
  output logic [7:0]  pixel_max_diff_o,
  output logic        frame_done_o,
  output logic [24:0] differing_pixels_o,
  output logic [24:0] above_threshold_pixels_o,
  output logic [7:0]  frame_max_diff_o,
  output logic [15:0] mean_diff_o,
  output logic [15:0] rms_diff_o
);
  import ids_pkg::*;

  ids_cmd_t              cmd;
  logic [NumCh-1:0][7:0] a_pix, b_pix, out_pix;

  // config writes are taken in any cycle; the block is idle by contract
  assign cfg_ready_o = 1'b1;

  assign a_pix = {a_ch3_i, a_ch2_i, a_ch1_i, a_ch0_i};
  assign b_pix = {b_ch3_i, b_ch2_i, b_ch1_i, b_ch0_i};

  ids_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_pixel_i (last_pixel_i),
    .in_ready_o   (in_ready_o),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd)
  );

  ids_datapath u_datapath (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cmd_i                    (cmd),
    .cfg_we_i                 (cfg_valid_i),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i),
    .a_i                      (a_pix),
    .b_i                      (b_pix),
    .out_ch_o                 (out_pix),
    .pixel_max_diff_o         (pixel_max_diff_o),
    .frame_done_o             (frame_done_o),
    .differing_pixels_o       (differing_pixels_o),
    .above_threshold_pixels_o (above_threshold_pixels_o),
    .frame_max_diff_o         (frame_max_diff_o),
    .mean_diff_o              (mean_diff_o),
    .rms_diff_o               (rms_diff_o)
  );

  assign out_ch0_o = out_pix[0];
  assign out_ch1_o = out_pix[1];
  assign out_ch2_o = out_pix[2];
  assign out_ch3_o = out_pix[3];

endmodule
